### rtl/core/brp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brp_pkg
// Shared types, codes and helper functions of the byte range parser.
// ----------------------------------------------------------------------------
package brp_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic [3:0] KEY_LEN = 4'd13;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [0:0] REG_OBJ_SIZE = 1'b0;

  localparam logic [1:0] VERDICT_WHOLE   = 2'd0;
  localparam logic [1:0] VERDICT_PARTIAL = 2'd1;
  localparam logic [1:0] VERDICT_UNSAT   = 2'd2;

  localparam logic [2:0] PH_SEARCH    = 3'd0;
  localparam logic [2:0] PH_EMPTY     = 3'd1;
  localparam logic [2:0] PH_FIRST     = 3'd2;
  localparam logic [2:0] PH_SFX_EMPTY = 3'd3;
  localparam logic [2:0] PH_SFX       = 3'd4;
  localparam logic [2:0] PH_DASH_EMPTY = 3'd5;
  localparam logic [2:0] PH_DASH      = 3'd6;

  localparam logic [1:0] NS_LEAD   = 2'd0;
  localparam logic [1:0] NS_SIGNED = 2'd1;
  localparam logic [1:0] NS_DIGITS = 2'd2;
  localparam logic [1:0] NS_DONE   = 2'd3;

  typedef struct packed {
    logic       bad;
    logic       neg;
    logic [1:0] stage;
  } num_flags_t;

  typedef struct packed {
    num_flags_t  fl;
    logic [63:0] mag;
  } num_t;

  typedef struct packed {
    logic [2:0] phase;
    num_t       n1;
    num_t       n2;
  } val_t;

  function automatic logic [7:0] key_char(logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h72;
      4'd1:    ch = 8'h61;
      4'd2:    ch = 8'h6e;
      4'd3:    ch = 8'h67;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h3a;
      4'd6:    ch = 8'h20;
      4'd7:    ch = 8'h62;
      4'd8:    ch = 8'h79;
      4'd9:    ch = 8'h74;
      4'd10:   ch = 8'h65;
      4'd11:   ch = 8'h73;
      4'd12:   ch = 8'h3d;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // stoull style digit accumulation, one character
  function automatic num_t num_feed(num_t n, logic [7:0] c);
    num_t        r;
    logic [67:0] wide;
    logic        digit;
    r     = n;
    digit = (c >= 8'h30) && (c <= 8'h39);
    wide  = ({4'b0, n.mag} << 3) + ({4'b0, n.mag} << 1) + {64'd0, c[3:0]};
    if (n.fl.stage != NS_DONE) begin
      if (digit) begin
        if (wide[67:64] != 4'd0) begin
          r.fl.bad = 1'b1;
        end else begin
          r.mag = wide[63:0];
        end
        r.fl.stage = NS_DIGITS;
      end else if (n.fl.stage == NS_LEAD) begin
        if (is_ws(c)) begin
          r = n;
        end else if (c == CH_PLUS) begin
          r.fl.stage = NS_SIGNED;
        end else if (c == CH_DASH) begin
          r.fl.stage = NS_SIGNED;
          r.fl.neg   = 1'b1;
        end else begin
          r.fl.stage = NS_DONE;
          r.fl.bad   = 1'b1;
        end
      end else if (n.fl.stage == NS_SIGNED) begin
        r.fl.stage = NS_DONE;
        r.fl.bad   = 1'b1;
      end else begin
        r.fl.stage = NS_DONE;
      end
    end
    return r;
  endfunction

  function automatic val_t val_feed(val_t v, logic [7:0] c);
    val_t r;
    r = v;
    case (v.phase) inside
      PH_EMPTY: begin
        if (c == CH_DASH) begin
          r.phase = PH_SFX_EMPTY;
        end else begin
          r.phase = PH_FIRST;
          r.n1    = num_feed(v.n1, c);
        end
      end
      PH_FIRST: begin
        if (c == CH_DASH) begin
          r.phase = PH_DASH_EMPTY;
        end else begin
          r.n1 = num_feed(v.n1, c);
        end
      end
      PH_SFX_EMPTY: begin
        r.phase = PH_SFX;
        r.n2    = num_feed(v.n2, c);
      end
      PH_DASH_EMPTY: begin
        r.phase = PH_DASH;
        r.n2    = num_feed(v.n2, c);
      end
      PH_SFX, PH_DASH: begin
        r.n2 = num_feed(v.n2, c);
      end
      default: begin
        r = v;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/brp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brp_if
// Valid/ready channels of the byte range parser: header text and result.
// ----------------------------------------------------------------------------
interface brp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface brp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [63:0] first_byte;
  logic [63:0] last_byte;

  modport source (output valid, output verdict, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input verdict, input first_byte, input last_byte,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/http_byte_range_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_byte_range_parser_core
// Streaming parser for the HTTP "range: bytes=" request header.
// ----------------------------------------------------------------------------
// Header text is taken one byte per clock with no gaps needed between
// transactions, save a text_last byte while the snapshot stage is full; the
// key match and value parse registers are updated once per byte, which sets
// that rate. Only a byte flagged text_last yields a result transaction, which
// passes through three finishing stages (snapshot, number values, range
// bounds) and the output register. Results back up in those stages, and other
// bytes keep being taken while a result waits. The object size is written
// over APB at address 0 and must only change while no header is in flight.
module http_byte_range_parser_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  brp_text_if.sink                             txt_i,
  brp_result_if.source                         res_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [brp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [brp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [brp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  // configuration
  logic [63:0] obj_size_q;
  logic [63:0] lim_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[brp_pkg::APB_ADDR_W-1] == brp_pkg::REG_OBJ_SIZE);
  assign prdata = (paddr[brp_pkg::APB_ADDR_W-1] == brp_pkg::REG_OBJ_SIZE) ?
                  obj_size_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_size_q <= '0;
      lim_q      <= '1;
    end else if (cfg_wr) begin
      obj_size_q <= pwdata;
      lim_q      <= pwdata - 64'd1;
    end
  end

  // pipeline control
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic out_free, s4_free, s3_free, s2_free, s1_free;
  logic s4_go, s3_go, s2_go, s1_go, in_acc;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  assign out_free = !out_v_q || res_o.ready;
  assign s4_go    = s4_v_q && out_free;
  assign s4_free  = !s4_v_q || out_free;
  assign s3_go    = s3_v_q && s4_free;
  assign s3_free  = !s3_v_q || s4_free;
  assign s2_go    = s2_v_q && s3_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_go    = s1_v_q && (!s1_last_q || s2_free);
  assign s1_free  = !s1_v_q || s1_go;
  assign txt_i.ready = s1_free;
  assign in_acc   = txt_i.valid && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= txt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= txt_i.text_byte;
      s1_last_q <= txt_i.text_last;
    end
  end

  // key match and value parse
  logic [3:0]    pos_q, pos_d;
  logic [2:0]    phase_q;
  logic          closed_q, closed_d;
  logic          pcr_q, pcr_d;
  brp_pkg::num_t n1_q, n2_q;
  brp_pkg::val_t cur, nxt, fin;
  logic [7:0]    lc;
  logic          handled;

  always_comb begin
    lc = s1_byte_q;
    if (s1_byte_q >= 8'h41 && s1_byte_q <= 8'h5a) begin
      lc = s1_byte_q + 8'd32;
    end
    cur       = '{phase: phase_q, n1: n1_q, n2: n2_q};
    nxt       = cur;
    pos_d     = pos_q;
    closed_d  = closed_q;
    pcr_d     = pcr_q;
    handled   = 1'b0;
    if (phase_q == brp_pkg::PH_SEARCH) begin
      if (pos_q < brp_pkg::KEY_LEN && lc == brp_pkg::key_char(pos_q)) begin
        pos_d = pos_q + 4'd1;
      end else begin
        pos_d = (lc == brp_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
      end
      if (pos_d >= brp_pkg::KEY_LEN) begin
        pos_d     = 4'd0;
        nxt.phase = brp_pkg::PH_EMPTY;
      end
    end else if (!closed_q) begin
      if (pcr_q) begin
        pcr_d = 1'b0;
        if (s1_byte_q == brp_pkg::CH_LF) begin
          closed_d = 1'b1;
          handled  = 1'b1;
        end else begin
          nxt = brp_pkg::val_feed(nxt, brp_pkg::CH_CR);
        end
      end
      if (!handled) begin
        if (s1_byte_q == brp_pkg::CH_CR) begin
          pcr_d = 1'b1;
        end else begin
          nxt = brp_pkg::val_feed(nxt, s1_byte_q);
        end
      end
    end
    fin = nxt;
    // a trailing cr at end of text belongs to the value
    if (nxt.phase != brp_pkg::PH_SEARCH && !closed_d && pcr_d) begin
      fin = brp_pkg::val_feed(nxt, brp_pkg::CH_CR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= brp_pkg::PH_SEARCH;
      closed_q <= 1'b0;
      pcr_q    <= 1'b0;
      n1_q     <= '0;
      n2_q     <= '0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        pos_q    <= '0;
        phase_q  <= brp_pkg::PH_SEARCH;
        closed_q <= 1'b0;
        pcr_q    <= 1'b0;
        n1_q     <= '0;
        n2_q     <= '0;
      end else begin
        pos_q    <= pos_d;
        phase_q  <= nxt.phase;
        closed_q <= closed_d;
        pcr_q    <= pcr_d;
        n1_q     <= nxt.n1;
        n2_q     <= nxt.n2;
      end
    end
  end

  // snapshot of the parse at end of text
  brp_pkg::val_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_go && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_go && s1_last_q) begin
      s2_q <= fin;
    end
  end

  // signed number values
  logic [2:0]  s3_phase_q;
  logic        s3_ok1_q, s3_ok2_q;
  logic [63:0] s3_n1_q, s3_n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_free) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      s3_phase_q <= s2_q.phase;
      s3_ok1_q   <= !s2_q.n1.fl.bad && s2_q.n1.fl.stage[1];
      s3_ok2_q   <= !s2_q.n2.fl.bad && s2_q.n2.fl.stage[1];
      s3_n1_q    <= s2_q.n1.fl.neg ? (64'd0 - s2_q.n1.mag) : s2_q.n1.mag;
      s3_n2_q    <= s2_q.n2.fl.neg ? (64'd0 - s2_q.n2.mag) : s2_q.n2.mag;
    end
  end

  // range bounds before clamping
  logic        s4_whole_q, s4_bad_q;
  logic [63:0] s4_s_q, s4_e_q;
  logic        s4_whole_d, s4_bad_d;
  logic [63:0] s4_s_d, s4_e_d;
  logic [64:0] sfx_diff;

  always_comb begin
    sfx_diff   = {1'b0, obj_size_q} - {1'b0, s3_n2_q};
    s4_whole_d = 1'b0;
    s4_bad_d   = 1'b1;
    s4_s_d     = '0;
    s4_e_d     = lim_q;
    case (s3_phase_q)
      brp_pkg::PH_SEARCH: begin
        s4_whole_d = 1'b1;
        s4_bad_d   = 1'b0;
        s4_e_d     = (obj_size_q == 64'd0) ? 64'd0 : lim_q;
      end
      brp_pkg::PH_SFX: begin
        s4_bad_d = !s3_ok2_q || (s3_n2_q == 64'd0);
        s4_s_d   = sfx_diff[64] ? 64'd0 : sfx_diff[63:0];
      end
      brp_pkg::PH_DASH_EMPTY: begin
        s4_bad_d = !s3_ok1_q;
        s4_s_d   = s3_n1_q;
      end
      brp_pkg::PH_DASH: begin
        s4_bad_d = !s3_ok1_q || !s3_ok2_q;
        s4_s_d   = s3_n1_q;
        s4_e_d   = s3_n2_q;
      end
      default: begin
        s4_bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (s4_free) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_go) begin
      s4_whole_q <= s4_whole_d;
      s4_bad_q   <= s4_bad_d;
      s4_s_q     <= s4_s_d;
      s4_e_q     <= s4_e_d;
    end
  end

  // verdict and clamp into the output register
  logic [1:0]  verdict_q, verdict_d;
  logic [63:0] first_q, first_d, last_q, last_d;

  always_comb begin
    if (s4_whole_q) begin
      verdict_d = brp_pkg::VERDICT_WHOLE;
      first_d   = s4_s_q;
      last_d    = s4_e_q;
    end else if (s4_bad_q || (s4_s_q >= obj_size_q) || (s4_e_q < s4_s_q)) begin
      verdict_d = brp_pkg::VERDICT_UNSAT;
      first_d   = '0;
      last_d    = '0;
    end else begin
      verdict_d = brp_pkg::VERDICT_PARTIAL;
      first_d   = s4_s_q;
      last_d    = (s4_e_q >= obj_size_q) ? lim_q : s4_e_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_go) begin
      verdict_q <= verdict_d;
      first_q   <= first_d;
      last_q    <= last_d;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.verdict    = verdict_q;
  assign res_o.first_byte = first_q;
  assign res_o.last_byte  = last_q;

endmodule
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for http_byte_range_parser_core. Header text is sent
// byte by byte with random gaps while the result side stalls at random. Every
// accepted byte also steps a local model of the key search and range parse.
// Each header closes with a byte flagged last, whose predicted verdict and
// byte positions are queued and checked against the result transactions in
// order. The object size is set over APB between headers, extremes included.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PCT = 36;
  localparam logic [8*13-1:0] RANGE_KEY = "range: bytes=";
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] DIGIT_ZERO = "0";
  localparam logic [7:0] DIGIT_NINE = "9";

  typedef struct packed {
    logic        bad;
    logic        neg;
    logic [1:0]  stage;
    logic [63:0] mag;
  } dec_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [63:0] first_byte;
    logic [63:0] last_byte;
  } range_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [brp_pkg::APB_ADDR_W-1:0] paddr;
  logic [brp_pkg::APB_DATA_W-1:0] pwdata;
  logic [brp_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  brp_text_if   txt ();
  brp_result_if res ();

  http_byte_range_parser_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .txt_i   (txt),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // parser model state
  logic [63:0] size_setting;
  logic [3:0]  key_pos;
  logic [2:0]  parse_phase;
  logic        value_closed;
  logic        cr_waiting;
  dec_t        num1;
  dec_t        num2;

  range_res_t  expected_ranges[$];
  range_res_t  front_range;
  logic [7:0]  hdr_q[$];
  int unsigned text_bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  bit          no_idle = 1'b0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("http_byte_range_parser_core: mismatch");
    $finish;
  end

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("error: %s", msg);
  endfunction

  function automatic logic [7:0] key_at(int unsigned pos);
    return RANGE_KEY[8*(brp_pkg::KEY_LEN-1-pos) +: 8];
  endfunction

  function automatic dec_t digit_step(dec_t n, logic [7:0] c);
    dec_t        r;
    logic [63:0] d;
    r = n;
    d = c - DIGIT_ZERO;
    if (n.stage == brp_pkg::NS_DONE) return r;
    if (c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
      if (n.mag > (~64'd0 - d) / 64'd10) begin
        r.bad = 1'b1;
      end else begin
        r.mag = n.mag * 64'd10 + d;
      end
      r.stage = brp_pkg::NS_DIGITS;
    end else if (n.stage == brp_pkg::NS_LEAD) begin
      if (c == brp_pkg::CH_PLUS) begin
        r.stage = brp_pkg::NS_SIGNED;
      end else if (c == brp_pkg::CH_DASH) begin
        r.stage = brp_pkg::NS_SIGNED;
        r.neg   = 1'b1;
      end else if (!(c == brp_pkg::CH_SPACE || (c >= CH_TAB && c <= brp_pkg::CH_CR))) begin
        r.stage = brp_pkg::NS_DONE;
        r.bad   = 1'b1;
      end
    end else if (n.stage == brp_pkg::NS_SIGNED) begin
      r.stage = brp_pkg::NS_DONE;
      r.bad   = 1'b1;
    end else begin
      r.stage = brp_pkg::NS_DONE;
    end
    return r;
  endfunction

  function automatic bit dec_ok(dec_t n);
    return !n.bad && n.stage >= brp_pkg::NS_DIGITS;
  endfunction

  function automatic logic [63:0] dec_value(dec_t n);
    return n.neg ? 64'd0 - n.mag : n.mag;
  endfunction

  function automatic void value_step(logic [7:0] c);
    case (parse_phase) inside
      brp_pkg::PH_EMPTY: begin
        if (c == brp_pkg::CH_DASH) begin
          parse_phase = brp_pkg::PH_SFX_EMPTY;
        end else begin
          parse_phase = brp_pkg::PH_FIRST;
          num1 = digit_step(num1, c);
        end
      end
      brp_pkg::PH_FIRST: begin
        if (c == brp_pkg::CH_DASH) begin
          parse_phase = brp_pkg::PH_DASH_EMPTY;
        end else begin
          num1 = digit_step(num1, c);
        end
      end
      brp_pkg::PH_SFX_EMPTY: begin
        parse_phase = brp_pkg::PH_SFX;
        num2 = digit_step(num2, c);
      end
      brp_pkg::PH_DASH_EMPTY: begin
        parse_phase = brp_pkg::PH_DASH;
        num2 = digit_step(num2, c);
      end
      brp_pkg::PH_SFX, brp_pkg::PH_DASH: begin
        num2 = digit_step(num2, c);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic range_res_t range_verdict();
    range_res_t  r;
    logic [63:0] lim;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] n;
    lim = size_setting - 64'd1;
    s = 64'd0;
    e = lim;
    r.verdict    = brp_pkg::VERDICT_UNSAT;
    r.first_byte = 64'd0;
    r.last_byte  = 64'd0;
    if (parse_phase == brp_pkg::PH_SEARCH) begin
      r.verdict   = brp_pkg::VERDICT_WHOLE;
      r.last_byte = (size_setting == 64'd0) ? 64'd0 : lim;
      return r;
    end
    if (parse_phase == brp_pkg::PH_SFX) begin
      n = dec_value(num2);
      if (!dec_ok(num2) || n == 64'd0) return r;
      s = (n >= size_setting) ? 64'd0 : size_setting - n;
    end else if (parse_phase == brp_pkg::PH_DASH_EMPTY ||
                 parse_phase == brp_pkg::PH_DASH) begin
      if (!dec_ok(num1)) return r;
      s = dec_value(num1);
      if (parse_phase == brp_pkg::PH_DASH) begin
        if (!dec_ok(num2)) return r;
        e = dec_value(num2);
      end
    end else begin
      return r;
    end
    if (s >= size_setting) return r;
    if (e > lim) e = lim;
    if (e < s) return r;
    r.verdict    = brp_pkg::VERDICT_PARTIAL;
    r.first_byte = s;
    r.last_byte  = e;
    return r;
  endfunction

  function automatic void clear_parse();
    key_pos      = 4'd0;
    parse_phase  = brp_pkg::PH_SEARCH;
    value_closed = 1'b0;
    cr_waiting   = 1'b0;
    num1         = '0;
    num2         = '0;
  endfunction

  function automatic void parse_header_byte(logic [7:0] c, logic is_last);
    logic [7:0] lc;
    bit         handled;
    handled = 1'b0;
    if (parse_phase == brp_pkg::PH_SEARCH) begin
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      if (key_pos < brp_pkg::KEY_LEN && lc == key_at(key_pos)) begin
        key_pos++;
      end else begin
        key_pos = (lc == key_at(0)) ? 4'd1 : 4'd0;
      end
      if (key_pos >= brp_pkg::KEY_LEN) begin
        key_pos     = 4'd0;
        parse_phase = brp_pkg::PH_EMPTY;
      end
    end else if (!value_closed) begin
      if (cr_waiting) begin
        cr_waiting = 1'b0;
        if (c == brp_pkg::CH_LF) begin
          value_closed = 1'b1;
          handled      = 1'b1;
        end else begin
          value_step(brp_pkg::CH_CR);
        end
      end
      if (!handled) begin
        if (c == brp_pkg::CH_CR) begin
          cr_waiting = 1'b1;
        end else begin
          value_step(c);
        end
      end
    end
    if (is_last) begin
      if (parse_phase != brp_pkg::PH_SEARCH && !value_closed && cr_waiting) begin
        value_step(brp_pkg::CH_CR);
      end
      expected_ranges.push_back(range_verdict());
      clear_parse();
    end
  endfunction

  // result side: random stalls, or a long hold-off counted here
  initial begin
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (expected_ranges.size() == 0) begin
        report_mismatch($sformatf("unexpected result verdict=%0d first=%0d last=%0d",
                                  res.verdict, res.first_byte, res.last_byte));
      end else begin
        front_range = expected_ranges.pop_front();
        if (res.verdict !== front_range.verdict ||
            res.first_byte !== front_range.first_byte ||
            res.last_byte !== front_range.last_byte) begin
          report_mismatch($sformatf(
            "result exp verdict=%0d first=%0d last=%0d, got verdict=%0d first=%0d last=%0d",
            front_range.verdict, front_range.first_byte, front_range.last_byte,
            res.verdict, res.first_byte, res.last_byte));
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic is_last);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      txt.valid <= 1'b0;
      @(posedge clk_i);
    end
    txt.valid     <= 1'b1;
    txt.text_byte <= b;
    txt.text_last <= is_last;
    do @(posedge clk_i); while (!txt.ready);
    text_bytes_sent++;
    parse_header_byte(b, is_last);
  endtask

  task automatic send_header();
    int unsigned i;
    for (i = 0; i < hdr_q.size(); i++) send_byte(hdr_q[i], i == hdr_q.size() - 1);
    hdr_q.delete();
  endtask

  task automatic put_byte(logic [7:0] b);
    hdr_q.push_back(b);
  endtask

  task automatic put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
  endtask

  task automatic send_text(string s);
    put_text(s);
    send_header();
  endtask

  task automatic wait_drained(int unsigned settle);
    txt.valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_obj_size(logic [63:0] v);
    wait_drained(8);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {brp_pkg::REG_OBJ_SIZE, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    size_setting = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== v) report_mismatch($sformatf("obj_size readback exp %0d got %0d", v, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic put_junk(int unsigned n);
    repeat (n) put_byte(8'($urandom_range(8'h20, 8'h7e)));
  endtask

  task automatic put_key(int unsigned upto);
    int unsigned i;
    logic [7:0]  ch;
    for (i = 0; i < upto; i++) begin
      ch = key_at(i);
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
      put_byte(ch);
    end
  endtask

  task automatic put_number();
    int unsigned sel;
    if ($urandom_range(0, 5) == 0) put_byte($urandom_range(0, 1) ? brp_pkg::CH_SPACE : CH_TAB);
    sel = $urandom_range(0, 19);
    if (sel == 0) put_byte(brp_pkg::CH_PLUS);
    if (sel == 1) put_byte(brp_pkg::CH_DASH);
    case ($urandom_range(0, 6))
      0, 1:    put_text($sformatf("%0d", $urandom_range(0, 99)));
      2, 3:    put_text($sformatf("%0d", size_setting + $urandom_range(0, 8) - 64'd4));
      4:       put_text($sformatf("%0d", {$urandom, $urandom}));
      5:       put_text($sformatf("%0d", size_setting >> $urandom_range(1, 8)));
      default: begin
        put_text("1844674407370955161");
        put_byte(DIGIT_ZERO + 8'($urandom_range(0, 9)));
      end
    endcase
    if ($urandom_range(0, 7) == 0) put_byte(8'($urandom_range("a", "z")));
  endtask

  task automatic build_random_header();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 24)) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 22) begin
      put_key($urandom_range(1, 12));
      put_junk($urandom_range(1, 6));
      if ($urandom_range(0, 1) == 0) return;
    end
    if ($urandom_range(0, 2) == 0) begin
      put_junk($urandom_range(1, 8));
      if ($urandom_range(0, 1)) begin
        put_byte(brp_pkg::CH_CR);
        put_byte(brp_pkg::CH_LF);
      end
    end
    put_key(brp_pkg::KEY_LEN);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        put_number();
        put_byte(brp_pkg::CH_DASH);
        put_number();
      end
      3, 4: begin
        put_number();
        put_byte(brp_pkg::CH_DASH);
      end
      5, 6: begin
        put_byte(brp_pkg::CH_DASH);
        put_number();
      end
      7: put_number();
      8: if ($urandom_range(0, 1)) put_byte(brp_pkg::CH_DASH);
      default: put_junk($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 5))
      1, 2: begin
        put_byte(brp_pkg::CH_CR);
        put_byte(brp_pkg::CH_LF);
      end
      3: begin
        put_byte(brp_pkg::CH_CR);
        put_byte(brp_pkg::CH_LF);
        if ($urandom_range(0, 1)) put_text("range: bytes=1-2");
        put_junk($urandom_range(1, 6));
      end
      4: put_byte(brp_pkg::CH_CR);
      5: begin
        put_byte(brp_pkg::CH_CR);
        put_junk(1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic random_phase(logic [63:0] fsz, int unsigned nbytes);
    int unsigned start;
    set_obj_size(fsz);
    start = text_bytes_sent;
    while (text_bytes_sent - start < nbytes) begin
      build_random_header();
      send_header();
    end
  endtask

  task automatic test_directed_ranges();
    send_text("range: bytes=0-1");
    set_obj_size(64'd1000);
    send_text("Host: example");
    send_text("Range: bytes=0-99");
    send_text("RANGE: BYTES=500-");
    send_text("range: bytes=-200");
    send_text("range: bytes=-0");
    send_text("range: bytes=-5000");
    send_text("range: bytes=");
    send_text("range: bytes=-");
    send_text("range: bytes=123");
    send_text("range: bytes=900-5000");
    send_text("range: bytes=500-100");
    send_text("range: bytes=1000-");
    put_text("range: bytes= ");
    put_byte(CH_TAB);
    send_text("+5-7");
    send_text("range: bytes=0--5");
    send_text("range: bytes=+-3-4");
    send_text("range: bytes=0-18446744073709551616");
    send_text("range: bytes=0-18446744073709551615");
    send_text("range: bytes=5-x");
    send_text("range: bytes=5-7abc");
    put_text("range: bytes=5-");
    put_byte(brp_pkg::CH_CR);
    send_text("7");
    put_text("range: bytes=5-9");
    put_byte(brp_pkg::CH_CR);
    send_header();
    put_text("range: bytes=5-9");
    put_byte(brp_pkg::CH_CR);
    put_byte(brp_pkg::CH_LF);
    send_text("range: bytes=1-2");
    send_text("rrange: range: bytes=3-4");
    send_text("range: bytes=-5-9");
  endtask

  task automatic size_cases(logic [63:0] fsz);
    set_obj_size(fsz);
    send_text("a");
    send_text("range: bytes=0-0");
    send_text("range: bytes=-1");
    send_text("range: bytes=18446744073709551614-");
  endtask

  task automatic test_size_extremes();
    size_cases(64'd0);
    size_cases(64'd1);
    size_cases(~64'd0);
  endtask

  // result side held off long enough for the core to back up into its input
  task automatic test_backpressure();
    int unsigned i;
    set_obj_size(64'd5000);
    hold_req = 400;
    for (i = 0; i < 40; i++) begin
      if (i % 4 == 3) begin
        send_text("range: bytes=1-2");
      end else begin
        put_byte(8'($urandom_range(0, 255)));
        send_header();
      end
    end
    wait_drained(0);
    send_text("range: bytes=-10");
  endtask

  task automatic test_random_headers();
    random_phase(64'd1000, 90);
    random_phase(64'($urandom_range(1, 4000)), 90);
    random_phase({$urandom, $urandom}, 90);
    random_phase(64'd0, 90);
    random_phase(64'd1, 90);
    random_phase(~64'd0, 90);
    random_phase(64'h8000_0000_0000_0000, 90);
  endtask

  task automatic test_no_idle_burst();
    no_idle = 1'b1;
    random_phase(64'd300, 110);
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    txt.valid     <= 1'b0;
    txt.text_byte <= 8'd0;
    txt.text_last <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    size_setting = 64'd0;
    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ranges();
    test_size_extremes();
    test_backpressure();
    test_random_headers();
    test_no_idle_burst();
    wait_drained(20);
    if (mismatches == 0) begin
      $display("http_byte_range_parser_core: match");
    end else begin
      $display("http_byte_range_parser_core: mismatch");
    end
    $finish;
  end

endmodule
